FILE: design/assert_macros.svh
// Assertion helpers for the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

FILE: design/lzwd_pkg.sv
package lzwd_pkg;
   localparam logic [7:0] MAGIC_FIRST  = 8'h1F;
   localparam logic [7:0] MAGIC_SECOND = 8'h9D;
   localparam logic [16:0] CLEAR_CODE  = 17'd256;
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_MAGIC     = 3'd1;
   localparam logic [2:0] ST_WIDTH     = 3'd2;
   localparam logic [2:0] ST_CODE      = 3'd3;
   localparam logic [2:0] ST_BUSY      = 3'd4;
   localparam logic REQ_DATA  = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;
endpackage

FILE: design/lzwd_dict.sv
// Dictionary memory: prefix and suffix per code, registered read.
module lzwd_dict (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [15:0] wr_addr,
   input  logic [15:0] wr_prefix,
   input  logic [7:0]  wr_suffix,
   input  logic [15:0] rd_addr,
   output logic [15:0] rd_prefix,
   output logic [7:0]  rd_suffix
);
   logic [15:0] prefix_mem [65536];
   logic [7:0]  suffix_mem [65536];
   logic        low_ff;
   logic [7:0]  low_sfx_ff;
   logic [7:0]  mem_sfx_ff;
   always_ff @(posedge clock) begin
      if (wr_en) begin
         prefix_mem[wr_addr] <= wr_prefix;
         suffix_mem[wr_addr] <= wr_suffix;
      end
      rd_prefix  <= prefix_mem[rd_addr];
      mem_sfx_ff <= suffix_mem[rd_addr];
      low_ff     <= (rd_addr[15:8] == 8'd0);
      low_sfx_ff <= rd_addr[7:0];
   end
   // root codes hold their own value
   assign rd_suffix = low_ff ? low_sfx_ff : mem_sfx_ff;
endmodule

FILE: design/lzwd_stack.sv
// String stack memory, one write and one registered read per cycle.
module lzwd_stack (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [15:0] wr_addr,
   input  logic [7:0]  wr_data,
   input  logic [15:0] rd_addr,
   output logic [7:0]  rd_data
);
   logic [7:0] mem [65536];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: design/lzw_stream_decoder.sv
// Channel | ports                                    | accepted when
// req     | req_valid req_stall req_type req_data_byte | req_valid & !req_stall
// rsp     | rsp_valid rsp_stall rsp_out_byte ...        | rsp_valid & !rsp_stall
// A drain of a non-empty stack goes through accept with stack read, pop, result;
// an empty drain and any other word that walks no prefix chain go from accept to result.
// A code that walks the chain goes through accept, first read, one dictionary
// read for each byte the walk pushes, and result.
// Reset is synchronous; dictionary and stack contents are not cleared.
// A stalled result holds; req_stall stays high until the next word may enter.
`include "assert_macros.svh"
module lzw_stream_decoder #(
   parameter int MAX_CODE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_valid,
   output logic [16:0] rsp_pending_count,
   output logic [2:0]  rsp_status
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DRAIN = 3'd1;
   localparam logic [2:0] S_WALK  = 3'd2;
   localparam logic [2:0] S_LAST  = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;
   localparam logic [4:0] MAX_W = 5'(MAX_CODE_BITS);

   logic [2:0]  state_ff, state_in;
   logic [16:0] level_ff, level_in;
   logic [1:0]  phase_ff, phase_in;
   logic [4:0]  wlimit_ff, wlimit_in;
   logic        block_ff, block_in;
   logic [4:0]  cwidth_ff, cwidth_in;
   logic [16:0] nfree_ff, nfree_in;
   logic [16:0] prev_ff, prev_in;
   logic        pvalid_ff, pvalid_in;
   logic [7:0]  lastc_ff, lastc_in;
   logic [23:0] buf_ff, buf_in;
   logic [4:0]  fill_ff, fill_in;
   logic [7:0]  goff_ff, goff_in;
   logic [7:0]  skip_ff, skip_in;
   logic [2:0]  err_ff, err_in;
   logic [16:0] walk_ff, walk_in;      // code being walked
   logic [16:0] incode_ff, incode_in;
   logic [7:0]  obyte_ff, obyte_in;
   logic        ovalid_ff, ovalid_in;
   logic [2:0]  ostat_ff, ostat_in;

   logic        d_we, s_we;
   logic [15:0] d_waddr, d_wpfx, d_raddr, d_rpfx, s_waddr, s_raddr;
   logic [7:0]  d_wsfx, d_rsfx, s_wdata, s_rdata;

   lzwd_dict u_dict (
      .clock(clock), .wr_en(d_we), .wr_addr(d_waddr), .wr_prefix(d_wpfx),
      .wr_suffix(d_wsfx), .rd_addr(d_raddr), .rd_prefix(d_rpfx), .rd_suffix(d_rsfx)
   );
   lzwd_stack u_stack (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
      .rd_addr(s_raddr), .rd_data(s_rdata)
   );

   logic accept;
   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_out_byte = obyte_ff;
   assign rsp_out_valid = ovalid_ff;
   assign rsp_pending_count = level_ff;
   assign rsp_status = ostat_ff;

   // Drop the rest of a group from the bit buffer; the remainder skips later.
   function automatic logic [36:0] skip_rest(input logic [4:0] cw, input logic [7:0] goff,
                                             input logic [23:0] b, input logic [4:0] f);
      logic [7:0] total, drop;
      total = (goff == 8'd0) ? 8'd0 : 8'({cw, 3'b000} - {3'b000, goff});
      drop  = (total < {3'b000, f}) ? total : {3'b000, f};
      return {b >> drop, 5'(f - drop[4:0]), 8'(total - drop)};
   endfunction

   always_comb begin
      logic [7:0]  bits;
      logic [3:0]  nb, d;
      logic [23:0] nbuf;
      logic [5:0]  nfill;
      logic [16:0] code, mask, maxc, maycode, nf;
      logic [8:0]  goffx;
      logic [7:0]  gmax;
      logic [36:0] sk;
      logic        full;
      state_in = state_ff; level_in = level_ff; phase_in = phase_ff;
      wlimit_in = wlimit_ff; block_in = block_ff; cwidth_in = cwidth_ff;
      nfree_in = nfree_ff; prev_in = prev_ff; pvalid_in = pvalid_ff;
      lastc_in = lastc_ff; buf_in = buf_ff; fill_in = fill_ff; goff_in = goff_ff;
      skip_in = skip_ff; err_in = err_ff; walk_in = walk_ff; incode_in = incode_ff;
      obyte_in = obyte_ff; ovalid_in = ovalid_ff; ostat_in = ostat_ff;
      d_we = 1'b0; d_waddr = nfree_ff[15:0]; d_wpfx = prev_ff[15:0]; d_wsfx = lastc_ff;
      d_raddr = walk_ff[15:0]; s_we = 1'b0; s_waddr = level_ff[15:0];
      s_wdata = lastc_ff; s_raddr = 16'(level_ff - 17'd1);
      bits = 8'd0; nb = 4'd0; d = 4'd0; nbuf = 24'd0; nfill = 6'd0; code = 17'd0;
      mask = 17'd0; maxc = 17'd0; maycode = 17'd0; nf = 17'd0; goffx = 9'd0;
      gmax = 8'd0; sk = 37'd0; full = 1'b0;
      case (state_ff)
         S_IDLE: if (accept) begin
            ovalid_in = 1'b0; obyte_in = 8'd0; ostat_in = err_ff;
            state_in = S_OUT;
            if (req_type == lzwd_pkg::REQ_DRAIN) begin
               // read top of stack now, pop next cycle
               if (level_ff != 17'd0) state_in = S_DRAIN;
            end else if (err_ff != lzwd_pkg::ST_OK) begin
               ostat_in = err_ff;
            end else if (level_ff != 17'd0) begin
               ostat_in = lzwd_pkg::ST_BUSY;
            end else if (phase_ff == 2'd0) begin
               if (req_data_byte != lzwd_pkg::MAGIC_FIRST) err_in = lzwd_pkg::ST_MAGIC;
               else phase_in = 2'd1;
               ostat_in = err_in;
            end else if (phase_ff == 2'd1) begin
               if (req_data_byte != lzwd_pkg::MAGIC_SECOND) err_in = lzwd_pkg::ST_MAGIC;
               else phase_in = 2'd2;
               ostat_in = err_in;
            end else if (phase_ff == 2'd2) begin
               wlimit_in = req_data_byte[4:0];
               block_in = req_data_byte[7];
               if (req_data_byte[4:0] > MAX_W) err_in = lzwd_pkg::ST_WIDTH;
               else begin
                  nfree_in = req_data_byte[7] ? 17'd257 : 17'd256;
                  cwidth_in = 5'd9; pvalid_in = 1'b0; phase_in = 2'd3;
               end
               ostat_in = err_in;
            end else begin
               bits = req_data_byte; nb = 4'd8;
               if (skip_ff != 8'd0) begin
                  d = (skip_ff < 8'd8) ? skip_ff[3:0] : 4'd8;
                  skip_in = skip_ff - {4'd0, d};
                  bits = bits >> d; nb = nb - d;
               end
               if (nb != 4'd0) begin
                  nbuf = buf_ff | ({16'd0, bits} << fill_ff);
                  nfill = {1'b0, fill_ff} + {2'd0, nb};
                  buf_in = nbuf; fill_in = nfill[4:0];
                  if (nfill >= {1'b0, cwidth_ff}) begin
                     mask = 17'((18'd1 << cwidth_ff) - 18'd1);
                     code = nbuf[16:0] & mask;
                     buf_in = nbuf >> cwidth_ff;
                     fill_in = 5'(nfill - {1'b0, cwidth_ff});
                     goffx = {1'b0, goff_ff} + {4'd0, cwidth_ff};
                     gmax = {cwidth_ff, 3'b000};
                     goff_in = (goffx >= {1'b0, gmax}) ? 8'd0 : goffx[7:0];
                     if (!pvalid_ff) begin
                        lastc_in = code[7:0];
                        s_we = 1'b1; s_waddr = 16'd0; s_wdata = code[7:0];
                        level_in = 17'd1; prev_in = code; pvalid_in = 1'b1;
                     end else if (code == lzwd_pkg::CLEAR_CODE && block_ff) begin
                        sk = skip_rest(cwidth_ff, goff_in, buf_in, fill_in);
                        buf_in = sk[36:13]; fill_in = sk[12:8]; skip_in = sk[7:0];
                        goff_in = 8'd0; nfree_in = 17'd256; cwidth_in = 5'd9;
                     end else if (code > nfree_ff) begin
                        err_in = lzwd_pkg::ST_CODE;
                     end else begin
                        incode_in = code;
                        walk_in = code;
                        if (code == nfree_ff) begin
                           s_we = 1'b1; s_waddr = 16'd0; s_wdata = lastc_ff;
                           level_in = 17'd1; walk_in = prev_ff;
                        end
                        state_in = S_WALK;
                     end
                  end
               end
               ostat_in = err_in;
            end
         end
         S_DRAIN: begin
            // read issued last cycle from level-1
            level_in = level_ff - 17'd1;
            obyte_in = s_rdata; ovalid_in = 1'b1; state_in = S_OUT;
         end
         S_WALK: begin
            // issue read of walk code; result arrives in S_LAST
            d_raddr = walk_ff[15:0];
            state_in = S_LAST;
         end
         S_LAST: begin
            if (walk_ff >= 17'd256 && level_ff < 17'h10000) begin
               s_we = 1'b1; s_wdata = d_rsfx; level_in = level_ff + 17'd1;
               walk_in = {1'b0, d_rpfx};
               d_raddr = d_rpfx;
               state_in = S_LAST;
            end else begin
               lastc_in = d_rsfx;
               if (level_ff < 17'h10000) begin
                  s_we = 1'b1; s_wdata = d_rsfx; level_in = level_ff + 17'd1;
               end
               maycode = 17'd1 << wlimit_ff;
               nf = nfree_ff;
               if (nfree_ff < maycode) begin
                  d_we = 1'b1; d_wsfx = d_rsfx; nf = nfree_ff + 17'd1;
               end
               nfree_in = nf;
               prev_in = incode_ff;
               full = (cwidth_ff == wlimit_ff) && (cwidth_ff != 5'd9);
               maxc = full ? maycode : 17'((18'd1 << cwidth_ff) - 18'd1);
               if (nf > maxc && cwidth_ff < 5'd16) begin
                  sk = skip_rest(cwidth_ff, goff_ff, buf_ff, fill_ff);
                  buf_in = sk[36:13]; fill_in = sk[12:8]; skip_in = sk[7:0];
                  goff_in = 8'd0; cwidth_in = cwidth_ff + 5'd1;
               end
               ostat_in = err_ff;
               state_in = S_OUT;
            end
         end
         S_OUT: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; level_ff <= 17'd0; phase_ff <= 2'd0; wlimit_ff <= 5'd0;
         block_ff <= 1'b0; cwidth_ff <= 5'd9; nfree_ff <= 17'd256; prev_ff <= 17'd0;
         pvalid_ff <= 1'b0; lastc_ff <= 8'd0; buf_ff <= 24'd0; fill_ff <= 5'd0;
         goff_ff <= 8'd0; skip_ff <= 8'd0; err_ff <= 3'd0;
      end else begin
         state_ff <= state_in; level_ff <= level_in; phase_ff <= phase_in;
         wlimit_ff <= wlimit_in; block_ff <= block_in; cwidth_ff <= cwidth_in;
         nfree_ff <= nfree_in; prev_ff <= prev_in; pvalid_ff <= pvalid_in;
         lastc_ff <= lastc_in; buf_ff <= buf_in; fill_ff <= fill_in; goff_ff <= goff_in;
         skip_ff <= skip_in; err_ff <= err_in;
      end
      walk_ff <= walk_in; incode_ff <= incode_in;
      obyte_ff <= obyte_in; ovalid_ff <= ovalid_in; ostat_ff <= ostat_in;
   end

   `ASSERT_IMPLIES(a_stall_busy, clock, reset, rsp_valid, req_stall)
   `ASSERT_NEXT(a_drain_pop, clock, reset, state_ff == S_DRAIN, level_ff == $past(level_ff) - 17'd1)
   `ASSERT_IMPLIES(a_fill_bound, clock, reset, 1'b1, fill_ff < 5'd24)
   `ASSERT_NEXT(a_hold_out, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status))
endmodule

FILE: test/tb_lzw_stream_decoder.sv
`timescale 1ns / 100ps

module tb_lzw_stream_decoder;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned RANDOM_CODES = 280;

   // One result word of the decoder.
   typedef struct {
      bit [7:0]  out_byte;
      bit        out_valid;
      bit [16:0] pending;
      bit [2:0]  status;
   } dec_word_type;

   // One row of the directed header table.
   typedef struct {
      bit           kind;
      bit [7:0]     data;
      bit           typed;
      dec_word_type want;
   } hdr_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_type;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_valid;
   logic [16:0] rsp_pending_count;
   logic [2:0]  rsp_status;

   lzw_stream_decoder u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_type(req_type), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte), .rsp_out_valid(rsp_out_valid),
      .rsp_pending_count(rsp_pending_count), .rsp_status(rsp_status)
   );

   // Bookkeeping shared by the driver, the receiver and the checker.
   dec_word_type expected_words[$];
   bit [7:0]    stream_bytes[$];
   bit          stream_bits[$];
   int unsigned err_count = 0;
   int unsigned words_sent = 0;
   int unsigned bytes_drained = 0;
   int unsigned busy_seen = 0;
   int unsigned cycles = 0;
   bit          hold_rsp = 0;

   // ---------------------------------------------------------------------
   // Decoder shadow: dictionary, string stack and bit unpacker.
   // ---------------------------------------------------------------------
   bit [15:0]   dict_prefix [65536];
   bit [7:0]    dict_suffix [65536];
   bit [7:0]    str_stack [65536];
   int unsigned stk_level, hdr_phase, lim_width, blk_mode, cur_width, free_code;
   int unsigned prev_code, last_ch, bit_buf, bit_fill, grp_off, skip_left, err_code;
   bit          have_prev;

   function void push_char(int unsigned b);
      if (stk_level < 65536) begin
         str_stack[stk_level] = b[7:0];
         stk_level++;
      end
   endfunction

   // Drop the rest of the current group, buffered bits first.
   function void drop_group_rest();
      int unsigned total, drop;
      total = (grp_off == 0) ? 0 : cur_width * 8 - grp_off;
      drop = (total < bit_fill) ? total : bit_fill;
      bit_buf = bit_buf >> drop;
      bit_fill -= drop;
      skip_left = total - drop;
      grp_off = 0;
   endfunction

   function void expand_code(int unsigned code);
      int unsigned incode, maycode, maxcode;
      if (!have_prev) begin
         last_ch = code & 8'hFF;
         push_char(last_ch);
         prev_code = code;
         have_prev = 1;
         return;
      end
      if (code == lzwd_pkg::CLEAR_CODE && blk_mode != 0) begin
         drop_group_rest();
         free_code = 256;
         cur_width = 9;
         return;
      end
      incode = code;
      if (code >= free_code) begin
         if (code > free_code) begin
            err_code = 32'(lzwd_pkg::ST_CODE);
            return;
         end
         push_char(last_ch);
         code = prev_code;
      end
      while (code >= 256 && stk_level < 65536) begin
         push_char(32'(dict_suffix[code & 16'hFFFF]));
         code = 32'(dict_prefix[code & 16'hFFFF]);
      end
      last_ch = 32'(dict_suffix[code & 16'hFFFF]);
      push_char(last_ch);
      maycode = 1 << lim_width;
      if (free_code < maycode) begin
         dict_prefix[free_code & 16'hFFFF] = prev_code[15:0];
         dict_suffix[free_code & 16'hFFFF] = last_ch[7:0];
         free_code++;
      end
      prev_code = incode;
      maxcode = (cur_width == lim_width && cur_width != 9) ? maycode
                                                           : ((1 << cur_width) - 1);
      if (free_code > maxcode && cur_width < 16) begin
         drop_group_rest();
         cur_width++;
      end
   endfunction

   function void take_stream_byte(bit [7:0] b);
      int unsigned bits, nb, d, code;
      bits = 32'(b);
      nb = 8;
      case (hdr_phase)
         0: begin
            if (b != lzwd_pkg::MAGIC_FIRST) err_code = 32'(lzwd_pkg::ST_MAGIC);
            else hdr_phase = 1;
            return;
         end
         1: begin
            if (b != lzwd_pkg::MAGIC_SECOND) err_code = 32'(lzwd_pkg::ST_MAGIC);
            else hdr_phase = 2;
            return;
         end
         2: begin
            lim_width = 32'(b[4:0]);
            blk_mode = 32'(b[7]);
            if (lim_width > 16) begin
               err_code = 32'(lzwd_pkg::ST_WIDTH);
               return;
            end
            free_code = (blk_mode != 0) ? 257 : 256;
            cur_width = 9;
            have_prev = 0;
            hdr_phase = 3;
            return;
         end
         default: ;
      endcase
      if (skip_left != 0) begin
         d = (skip_left < 8) ? skip_left : 8;
         skip_left -= d;
         bits = bits >> d;
         nb -= d;
      end
      if (nb == 0) return;
      bit_buf = bit_buf | (bits << bit_fill);
      bit_fill += nb;
      if (bit_fill >= cur_width) begin
         code = bit_buf & ((1 << cur_width) - 1);
         bit_buf = bit_buf >> cur_width;
         bit_fill -= cur_width;
         grp_off += cur_width;
         if (grp_off >= cur_width * 8) grp_off = 0;
         expand_code(code);
      end
   endfunction

   // Advance the shadow by one word and return the result it causes.
   function dec_word_type decode_word(bit kind, bit [7:0] b);
      dec_word_type w;
      w.out_byte = 0;
      w.out_valid = 0;
      if (kind == lzwd_pkg::REQ_DRAIN) begin
         if (stk_level > 0) begin
            stk_level--;
            w.out_byte = str_stack[stk_level];
            w.out_valid = 1;
         end
         w.status = err_code[2:0];
      end else if (err_code != 0) begin
         w.status = err_code[2:0];
      end else if (stk_level > 0) begin
         w.status = lzwd_pkg::ST_BUSY;
      end else begin
         take_stream_byte(b);
         w.status = err_code[2:0];
      end
      w.pending = stk_level[16:0];
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // Stream packer: mirrors the code width and group bookkeeping so that
   // the generated codes line up with what the decoder expects.
   // ---------------------------------------------------------------------
   int unsigned pk_width, pk_free, pk_off, pk_lim, pk_blk;
   bit          pk_first;

   function void pad_group();
      int unsigned total;
      total = (pk_off == 0) ? 0 : pk_width * 8 - pk_off;
      repeat (total) stream_bits.push_back(1'b0);
      pk_off = 0;
   endfunction

   function void pack_code(int unsigned c);
      int unsigned maxc;
      for (int i = 0; i < pk_width; i++) stream_bits.push_back(c[i]);
      pk_off += pk_width;
      if (pk_off >= pk_width * 8) pk_off = 0;
      if (pk_first) begin
         pk_first = 0;
         return;
      end
      if (c == lzwd_pkg::CLEAR_CODE && pk_blk != 0) begin
         pad_group();
         pk_free = 256;
         pk_width = 9;
         return;
      end
      if (pk_free < (1 << pk_lim)) pk_free++;
      maxc = (pk_width == pk_lim && pk_width != 9) ? (1 << pk_lim) : ((1 << pk_width) - 1);
      if (pk_free > maxc && pk_width < 16) begin
         pad_group();
         pk_width++;
      end
   endfunction

   // Pick a code that the decoder can resolve from entries it has built.
   function int unsigned pick_code();
      int unsigned r, low;
      r = $urandom_range(99);
      low = (pk_blk != 0) ? 257 : 256;
      if (r < 8 && pk_blk != 0) return 32'(lzwd_pkg::CLEAR_CODE);
      if (r < 20 && !(pk_blk != 0 && pk_free == 256)) return pk_free;
      if (r < 65 && pk_free > low) return $urandom_range(pk_free - 1, low);
      return $urandom_range(255);
   endfunction

   function void bits_to_bytes();
      bit [7:0] b;
      while (stream_bits.size() % 8 != 0) stream_bits.push_back(1'b0);
      while (stream_bits.size() != 0) begin
         for (int i = 0; i < 8; i++) b[i] = stream_bits.pop_front();
         stream_bytes.push_back(b);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Clock, cycle limit, and the idling profile by phase of the run.
   // ---------------------------------------------------------------------
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycles,
                  expected_words.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Phases rotate every 100 words: no idling, sender idle, receiver stall, both.
   function int unsigned send_idle_pct();
      case ((words_sent / 100) % 4)
         1: return 79;
         3: return 32;
         default: return 0;
      endcase
   endfunction

   function int unsigned rsp_stall_pct();
      case ((words_sent / 100) % 4)
         2: return 79;
         3: return 32;
         default: return 0;
      endcase
   endfunction

   // Receiver: stall at random, or hold off entirely during the long stretch.
   initial begin
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         rsp_stall = hold_rsp || ($urandom_range(99) < rsp_stall_pct());
      end
   end

   // Long hold-off, counted in cycles, so the decoder backs up into req_stall.
   initial begin
      wait (words_sent >= 300);
      @(negedge clock);
      hold_rsp = 1;
      repeat (400) @(negedge clock);
      hold_rsp = 0;
   end

   // ---------------------------------------------------------------------
   // Checker: compare each accepted result word with the oldest expectation.
   // ---------------------------------------------------------------------
   task automatic report(string what, int got, int want);
      $display("mismatch at cycle %0d: %s got %0d, expected %0d", cycles, what, got, want);
      err_count++;
   endtask

   always @(posedge clock) begin
      dec_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            report("unexpected word, status", rsp_status, -1);
         end else begin
            w = expected_words.pop_front();
            if (rsp_out_valid !== w.out_valid) report("out_valid", rsp_out_valid, w.out_valid);
            if (rsp_out_byte !== w.out_byte) report("out_byte", rsp_out_byte, w.out_byte);
            if (rsp_pending_count !== w.pending)
               report("pending_count", rsp_pending_count, w.pending);
            if (rsp_status !== w.status) report("status", rsp_status, w.status);
            if (w.out_valid) bytes_drained++;
            if (w.status == lzwd_pkg::ST_BUSY) busy_seen++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender: offer one word, hold it until accepted, then advance the shadow.
   // ---------------------------------------------------------------------
   task automatic send_word(bit kind, bit [7:0] b, bit typed, dec_word_type want);
      dec_word_type w;
      while ($urandom_range(99) < send_idle_pct()) begin
         req_valid = 0;
         req_type = 1'($urandom_range(1));
         req_data_byte = 8'($urandom_range(255));
         @(negedge clock);
      end
      req_valid = 1;
      req_type = kind;
      req_data_byte = b;
      do @(posedge clock); while (req_stall);
      w = decode_word(kind, b);
      expected_words.push_back(typed ? want : w);
      words_sent++;
      @(negedge clock);
      req_valid = 0;
   endtask

   // Drain while bytes are pending, with the odd refused byte; else feed the stream, with the odd empty drain.
   task automatic run_stream();
      dec_word_type none;
      bit           paused;
      paused = 0;
      none = '{default: 0};
      while (stream_bytes.size() != 0 || stk_level != 0) begin
         if (!paused && words_sent >= 700) begin
            paused = 1;
            while (expected_words.size() != 0) @(negedge clock);
         end
         if (stk_level != 0) begin
            if ($urandom_range(7) == 0)
               send_word(lzwd_pkg::REQ_DATA, 8'($urandom_range(255)), 0, none);
            else send_word(lzwd_pkg::REQ_DRAIN, 8'($urandom_range(255)), 0, none);
         end else if ($urandom_range(15) == 0) begin
            send_word(lzwd_pkg::REQ_DRAIN, 8'($urandom_range(255)), 0, none);
         end else begin
            send_word(lzwd_pkg::REQ_DATA, stream_bytes.pop_front(), 0, none);
         end
      end
   endtask

   initial begin
      hdr_row_type hdr_rows[$];
      hdr_row_type row;
      dec_word_type idle_ok;
      int unsigned directed_codes[$];
      bit [7:0]    flags;
      int unsigned bad;

      reset = 1;
      req_valid = 0;
      req_type = lzwd_pkg::REQ_DATA;
      req_data_byte = 0;

      // Hold the shadow at its reset state.
      for (int i = 0; i < 65536; i++) begin
         dict_prefix[i] = 0;
         dict_suffix[i] = (i < 256) ? i[7:0] : 8'h00;
         str_stack[i] = 0;
      end
      stk_level = 0; hdr_phase = 0; lim_width = 0; blk_mode = 0; cur_width = 9;
      free_code = 256; prev_code = 0; have_prev = 0; last_ch = 0; bit_buf = 0;
      bit_fill = 0; grp_off = 0; skip_left = 0; err_code = 0;

      // Flags: width limit 9..16, block mode at random, unused bits at random.
      // A limit below 9 in block mode would read unbuilt entries, so keep clear of it.
      flags = {$urandom_range(1) == 1'b1, 2'($urandom_range(3)), 5'($urandom_range(16, 9))};
      pk_lim = 32'(flags[4:0]);
      pk_blk = 32'(flags[7]);
      pk_width = 9;
      pk_free = (pk_blk != 0) ? 257 : 256;
      pk_off = 0;
      pk_first = 1;

      // Directed header: empty drain, both magic bytes, flags, empty drain.
      idle_ok = '{default: 0};
      hdr_rows.push_back('{lzwd_pkg::REQ_DRAIN, 8'h00, 1, idle_ok});
      hdr_rows.push_back('{lzwd_pkg::REQ_DATA, lzwd_pkg::MAGIC_FIRST, 1, idle_ok});
      hdr_rows.push_back('{lzwd_pkg::REQ_DATA, lzwd_pkg::MAGIC_SECOND, 1, idle_ok});
      hdr_rows.push_back('{lzwd_pkg::REQ_DATA, flags, 1, idle_ok});
      hdr_rows.push_back('{lzwd_pkg::REQ_DRAIN, 8'hFF, 1, idle_ok});

      // Directed codes: literal extremes, repeated-string case, existing entry,
      // a clear and the repeated-string case right after it.
      directed_codes = '{0, 255, 0, 0, 65, 66, 65, 255};
      foreach (directed_codes[i]) pack_code(directed_codes[i]);
      pack_code(pk_free);
      pack_code(pk_free - 1);
      if (pk_blk != 0) begin
         pack_code(32'(lzwd_pkg::CLEAR_CODE));
         pack_code(200);
         pack_code(pk_free);
      end
      repeat (RANDOM_CODES) pack_code(pick_code());

      // End on a code beyond the next free one; the error then sticks.
      while (((1 << pk_width) - 1) <= pk_free) pack_code($urandom_range(255));
      bad = (1 << pk_width) - 1;
      pack_code(bad);
      bits_to_bytes();
      repeat (6) stream_bytes.push_back(8'($urandom_range(255)));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (hdr_rows[i]) begin
         row = hdr_rows[i];
         send_word(row.kind, row.data, row.typed, row.want);
      end
      run_stream();

      while (expected_words.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);

      $display("run: %0d words sent, %0d bytes drained, %0d refused as busy",
               words_sent, bytes_drained, busy_seen);
      $display("stream: width limit %0d, block mode %0d, final code width %0d, status %0d",
               lim_width, blk_mode, cur_width, err_code);
      if (err_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", err_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+design
design/lzwd_pkg.sv
design/lzwd_dict.sv
design/lzwd_stack.sv
design/lzw_stream_decoder.sv
test/tb_lzw_stream_decoder.sv
